// ===== hdl/tilp_pkg.sv =====
// Package for the telnet input line parser: byte codes, parse modes,
// result kinds, sequencer states and the line buffer command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tilp_pkg;

    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_SB   = 8'd250;
    localparam logic [7:0] BYTE_SE   = 8'd240;
    localparam logic [7:0] BYTE_DEL  = 8'h7f;
    localparam logic [7:0] BYTE_BS   = 8'd8;
    localparam logic [7:0] BYTE_LF   = 8'd10;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_NUL  = 8'd0;

    typedef enum logic [2:0] {
        MODE_DATA   = 3'd0,
        MODE_IAC    = 3'd1,
        MODE_OPT    = 3'd2,
        MODE_SUB    = 3'd3,
        MODE_SUBIAC = 3'd4
    } tilp_mode_t;

    typedef enum logic [1:0] {
        KIND_REPLY   = 2'd0,
        KIND_CHAR    = 2'd1,
        KIND_END     = 2'd2,
        KIND_DISCARD = 2'd3
    } tilp_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_REPLY = 3'd1,
        ST_LRD   = 3'd2,
        ST_LOUT  = 3'd3,
        ST_END   = 3'd4,
        ST_DISC  = 3'd5
    } tilp_state_t;

    // Command bundle from the parser to the line buffer.
    typedef struct packed {
        logic push;   // append a character (or mark overflow)
        logic erase;  // remove the last character if allowed
        logic clear;  // newline: empty the line and drop the overflow mark
        logic rd_en;  // read the store at the given address
    } tilp_line_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tilp_line_buf.sv =====
// Line buffer of the telnet input line parser: character store in a
// synchronous memory, fill count and overflow mark.
// Depends on tilp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tilp_line_buf
    import tilp_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    localparam int ADDR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tilp_line_cmd_t    cmd,
    input  wire logic [7:0]        wr_byte,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0]      length,
    output logic                   too_long,
    output logic [7:0]             rd_data
);

    localparam logic [ADDR_W-1:0] MAX_LEN = ADDR_W'(LINE_BYTES - 1);

    logic [7:0]        store_mem [LINE_BYTES];
    logic [ADDR_W-1:0] length_reg, length_next;
    logic              too_long_reg, too_long_next;
    logic [7:0]        rd_data_reg;
    logic              wr_en;

    always_comb begin
        length_next   = length_reg;
        too_long_next = too_long_reg;
        wr_en         = 1'b0;
        if (cmd.clear) begin
            length_next   = '0;
            too_long_next = 1'b0;
        end else if (cmd.erase) begin
            if (!too_long_reg && length_reg != '0) begin
                length_next = length_reg - 1'b1;
            end
        end else if (cmd.push) begin
            if (length_reg < MAX_LEN) begin
                wr_en       = 1'b1;
                length_next = length_reg + 1'b1;
            end else begin
                too_long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg   <= '0;
            too_long_reg <= 1'b0;
        end else begin
            length_reg   <= length_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[length_reg] <= wr_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign length   = length_reg;
    assign too_long = too_long_reg;
    assign rd_data  = rd_data_reg;

    // The overflow mark is only ever set on a full line, and a full line
    // cannot shrink while the mark stands.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> length_reg == MAX_LEN)
        else $error("overflow mark set on a line that is not full");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= MAX_LEN)
        else $error("line length beyond capacity");

    a_erase_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.erase && !cmd.clear && length_reg == '0) |=> length_reg == '0)
        else $error("erase on an empty line changed its length");

endmodule

`default_nettype wire

// ===== hdl/telnet_input_line_parser.sv =====
// Top level of the telnet input line parser: command stripping, option
// refusal, line assembly and read-out through an output register.
// Depends on tilp_pkg and tilp_line_buf.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                      Content
// s_        in         tvalid tready tdata[7:0]   received byte
// m_        out        tvalid tready tdata[7:0]   reply byte or line character
//                      tuser[1:0] tlast           result kind, last of the item
//
// A refused option sends three reply bytes. On a newline, each stored
// character is first read from the synchronous store and then loaded
// into the output register, and the line-end item follows the last
// character; an overflowed line sends only its discard item. While
// results are being sent, s_tready is low.
// Reset (aresetn low at a clock edge) returns the parser to the data
// state with an empty line; no clearing pass runs over the store.
// A stalled m_tready holds the output register and the states that load it.

module telnet_input_line_parser
    import tilp_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input item.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    // Result item.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] data_byte
    output logic [1:0]      m_tuser,   // [1:0] kind
    output logic            m_tlast    // last result caused by the input byte
);

    localparam int ADDR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

    // Parser and sequencer registers.
    tilp_state_t       state_reg, state_next;
    tilp_mode_t        mode_reg, mode_next;
    logic [7:0]        pending_reg, pending_next;
    logic [7:0]        reply_cmd_reg, reply_cmd_next;
    logic [7:0]        option_reg, option_next;
    logic [1:0]        rep_idx_reg, rep_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] emit_len_reg, emit_len_next;

    // Output register.
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    tilp_kind_t        m_tuser_reg;
    logic              m_tlast_reg;

    // Line buffer interface.
    tilp_line_cmd_t    line_cmd;
    logic [ADDR_W-1:0] line_length;
    logic              line_too_long;
    logic [7:0]        line_rd_data;

    logic              in_accept;
    logic              out_free;
    logic              emit_valid;
    tilp_kind_t        emit_kind;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic              data_in;
    logic [7:0]        rx_byte;

    assign rx_byte   = s_tdata;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // The output register can take a new item when empty or being drained.
    assign out_free  = !m_tvalid_reg || m_tready;

    tilp_line_buf #(
        .LINE_BYTES(LINE_BYTES)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (line_cmd),
        .wr_byte  (rx_byte),
        .rd_addr  (rd_idx_reg),
        .length   (line_length),
        .too_long (line_too_long),
        .rd_data  (line_rd_data)
    );

    // Next state, byte parsing and result emission.
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pending_next   = pending_reg;
        reply_cmd_next = reply_cmd_reg;
        option_next    = option_reg;
        rep_idx_next   = rep_idx_reg;
        rd_idx_next    = rd_idx_reg;
        emit_len_next  = emit_len_reg;
        line_cmd       = '0;
        emit_valid     = 1'b0;
        emit_kind      = KIND_REPLY;
        emit_byte      = 8'd0;
        emit_last      = 1'b0;
        data_in        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (mode_reg)
                        MODE_IAC: begin
                            if (rx_byte == BYTE_IAC) begin
                                // Escaped IAC: a plain data byte of 255.
                                mode_next = MODE_DATA;
                                data_in   = 1'b1;
                            end else if (rx_byte inside {BYTE_WILL, BYTE_WONT,
                                                         BYTE_DO, BYTE_DONT}) begin
                                pending_next = rx_byte;
                                mode_next    = MODE_OPT;
                            end else if (rx_byte == BYTE_SB) begin
                                mode_next = MODE_SUB;
                            end else begin
                                mode_next = MODE_DATA;
                            end
                        end
                        MODE_OPT: begin
                            mode_next = MODE_DATA;
                            if (pending_reg == BYTE_WILL || pending_reg == BYTE_DO) begin
                                reply_cmd_next = (pending_reg == BYTE_WILL) ?
                                                 BYTE_DONT : BYTE_WONT;
                                option_next    = rx_byte;
                                rep_idx_next   = 2'd0;
                                state_next     = ST_REPLY;
                            end
                        end
                        MODE_SUB: begin
                            if (rx_byte == BYTE_IAC) begin
                                mode_next = MODE_SUBIAC;
                            end
                        end
                        MODE_SUBIAC: begin
                            mode_next = (rx_byte == BYTE_SE) ? MODE_DATA : MODE_SUB;
                        end
                        default: begin
                            mode_next = MODE_DATA;
                            if (rx_byte == BYTE_IAC) begin
                                mode_next = MODE_IAC;
                            end else begin
                                data_in = 1'b1;
                            end
                        end
                    endcase

                    if (data_in) begin
                        if (rx_byte == BYTE_CR || rx_byte == BYTE_NUL) begin
                            line_cmd = '0;
                        end else if (rx_byte == BYTE_BS || rx_byte == BYTE_DEL) begin
                            line_cmd.erase = 1'b1;
                        end else if (rx_byte == BYTE_LF) begin
                            line_cmd.clear = 1'b1;
                            emit_len_next  = line_length;
                            rd_idx_next    = '0;
                            if (line_too_long) begin
                                state_next = ST_DISC;
                            end else if (line_length == '0) begin
                                state_next = ST_END;
                            end else begin
                                state_next = ST_LRD;
                            end
                        end else begin
                            line_cmd.push = 1'b1;
                        end
                    end
                end
            end

            ST_REPLY: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_REPLY;
                    case (rep_idx_reg)
                        2'd0:    emit_byte = BYTE_IAC;
                        2'd1:    emit_byte = reply_cmd_reg;
                        default: emit_byte = option_reg;
                    endcase
                    if (rep_idx_reg == 2'd2) begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        rep_idx_next = rep_idx_reg + 2'd1;
                    end
                end
            end

            ST_LRD: begin
                line_cmd.rd_en = 1'b1;
                state_next     = ST_LOUT;
            end

            ST_LOUT: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_CHAR;
                    emit_byte  = line_rd_data;
                    if (rd_idx_reg + 1'b1 == emit_len_reg) begin
                        state_next = ST_END;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_LRD;
                    end
                end
            end

            ST_END: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_END;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DISC: begin
                if (out_free) begin
                    emit_valid = 1'b1;
                    emit_kind  = KIND_DISCARD;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_DATA;
            pending_reg <= 8'd0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        reply_cmd_reg <= reply_cmd_next;
        option_reg    <= option_next;
        rep_idx_reg   <= rep_idx_next;
        rd_idx_reg    <= rd_idx_next;
        emit_len_reg  <= emit_len_next;
    end

    // Output register: loaded by the sequencer, emptied by the consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_tdata_reg <= emit_byte;
            m_tuser_reg <= emit_kind;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A refused option must start its three-byte reply right away.
    a_reply_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && mode_reg == MODE_OPT &&
         (pending_reg == BYTE_WILL || pending_reg == BYTE_DO))
        |=> state_reg == ST_REPLY)
        else $error("option refusal did not start a reply");

    // Character output always follows a store read, perhaps after output stalls.
    a_read_before_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOUT) |->
        ($past(state_reg) == ST_LRD || $past(state_reg) == ST_LOUT))
        else $error("line character sent without a store read");

    a_read_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LRD || state_reg == ST_LOUT) |-> rd_idx_reg < emit_len_reg)
        else $error("line read-out index past the stored length");

    // The read-out must not be disturbed by line buffer writes.
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !(line_cmd.push || line_cmd.erase || line_cmd.clear))
        else $error("line buffer modified while results are pending");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the telnet input line parser: random and directed
// byte streams, with a transaction-level predictor of replies and emitted lines.
// Depends on tilp_pkg and the telnet_input_line_parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import tilp_pkg::*;

    localparam int LINE_BYTES     = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 250;
    // Longest read-out is a full line: each character is read, then sent, then the end item.
    localparam int DRAIN_CYCLES   = 2 * LINE_BYTES + 20;

    typedef struct packed {
        tilp_kind_t kind;
        logic [7:0] data;
        logic       last;
    } parser_result_t;

    // Predicts the results that each received byte causes and holds them in
    // arrival order until the block sends them.
    class line_parser_predictor;
        tilp_mode_t     mode;
        logic [7:0]     held_cmd;
        logic [7:0]     text [LINE_BYTES];
        int             text_len;
        bit             overflowed;
        parser_result_t due [$];
        int             errors;
        tilp_kind_t     step_kind [LINE_BYTES + 4];
        logic [7:0]     step_data [LINE_BYTES + 4];
        int             step_n;

        function new();
            mode       = MODE_DATA;
            held_cmd   = 8'h00;
            text_len   = 0;
            overflowed = 1'b0;
            errors     = 0;
        endfunction

        function void emit(tilp_kind_t k, logic [7:0] d);
            step_kind[step_n] = k;
            step_data[step_n] = d;
            step_n++;
        endfunction

        // Line assembly for a byte that reached the data path.
        function void take_text(logic [7:0] b);
            int i;
            if (b == BYTE_CR || b == BYTE_NUL)
                return;
            if (b == BYTE_BS || b == BYTE_DEL) begin
                if (!overflowed && text_len > 0)
                    text_len--;
                return;
            end
            if (b == BYTE_LF) begin
                if (overflowed) begin
                    emit(KIND_DISCARD, 8'h00);
                end else begin
                    for (i = 0; i < text_len; i++)
                        emit(KIND_CHAR, text[i]);
                    emit(KIND_END, 8'h00);
                end
                text_len   = 0;
                overflowed = 1'b0;
                return;
            end
            if (text_len < LINE_BYTES - 1) begin
                text[text_len] = b;
                text_len++;
            end else begin
                overflowed = 1'b1;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            int             i;
            parser_result_t r;
            step_n = 0;
            case (mode)
                MODE_IAC: begin
                    if (b == BYTE_IAC) begin
                        mode = MODE_DATA;
                        take_text(b);
                    end else if (b == BYTE_WILL || b == BYTE_WONT ||
                                 b == BYTE_DO || b == BYTE_DONT) begin
                        held_cmd = b;
                        mode     = MODE_OPT;
                    end else if (b == BYTE_SB) begin
                        mode = MODE_SUB;
                    end else begin
                        mode = MODE_DATA;
                    end
                end
                MODE_OPT: begin
                    // Offers to enable an option are always refused.
                    if (held_cmd == BYTE_WILL || held_cmd == BYTE_DO) begin
                        emit(KIND_REPLY, BYTE_IAC);
                        emit(KIND_REPLY, (held_cmd == BYTE_WILL) ? BYTE_DONT : BYTE_WONT);
                        emit(KIND_REPLY, b);
                    end
                    mode = MODE_DATA;
                end
                MODE_SUB: begin
                    if (b == BYTE_IAC)
                        mode = MODE_SUBIAC;
                end
                MODE_SUBIAC: begin
                    if (b == BYTE_SE)
                        mode = MODE_DATA;
                    else
                        mode = MODE_SUB;
                end
                default: begin
                    if (b == BYTE_IAC) begin
                        mode = MODE_IAC;
                    end else begin
                        mode = MODE_DATA;
                        take_text(b);
                    end
                end
            endcase
            for (i = 0; i < step_n; i++) begin
                r.kind = step_kind[i];
                r.data = step_data[i];
                r.last = (i == step_n - 1);
                due.push_back(r);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            parser_result_t want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind %0d data %02h last %0b",
                             $realtime, kind, data, last);
                return;
            end
            want = due.pop_front();
            if (kind !== want.kind || data !== want.data || last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch, expected kind %0d data %02h last %0b,",
                              " got kind %0d data %02h last %0b"},
                             $realtime, want.kind, want.data, want.last,
                             kind, data, last);
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    line_parser_predictor rx_predictor;

    bit idle_on  = 1'b1;   // sender inserts random gaps
    bit stall_on = 1'b1;   // receiver drops tready at random
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off
    int hold_left  = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always #6 aclk = ~aclk;

    telnet_input_line_parser #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Result side: check every accepted item, then choose tready for the next
    // cycle. The long hold-off is counted here so the sender keeps offering.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            rx_predictor.check_result(m_tuser, m_tdata, m_tlast);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(stall_on && $urandom_range(0, 99) < 33);
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        rx_predictor.note_byte(b);
        items_sent++;
    endtask

    // A non-NUL, non-IAC byte with no line-editing meaning.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 254));
        while (b == BYTE_BS || b == BYTE_LF || b == BYTE_CR || b == BYTE_DEL);
        return b;
    endfunction

    task automatic send_option(input logic [7:0] cmd, input logic [7:0] opt);
        send_byte(BYTE_IAC);
        send_byte(cmd);
        send_byte(opt);
    endtask

    function automatic logic [7:0] pick_option_cmd();
        case ($urandom_range(0, 3))
            0: return BYTE_WILL;
            1: return BYTE_WONT;
            2: return BYTE_DO;
            default: return BYTE_DONT;
        endcase
    endfunction

    // Line body without its newline. A messy body mixes in edits, dropped
    // bytes, escaped IAC and option requests between the characters.
    task automatic send_text(input int n, input bit messy);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = messy ? $urandom_range(0, 99) : 0;
            if (r < 80)       send_byte(pick_text_byte());
            else if (r < 84)  send_byte(BYTE_BS);
            else if (r < 88)  send_byte(BYTE_DEL);
            else if (r < 91)  send_byte(BYTE_CR);
            else if (r < 93)  send_byte(BYTE_NUL);
            else if (r < 96) begin
                send_byte(BYTE_IAC);
                send_byte(BYTE_IAC);
            end else begin
                send_option(pick_option_cmd(), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_subneg();
        int i;
        int n;
        logic [7:0] b;
        send_byte(BYTE_IAC);
        send_byte(BYTE_SB);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
            // An IAC inside the block must not be followed by SE here.
            if (b == BYTE_IAC) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == BYTE_SE);
                send_byte(b);
            end
        end
        send_byte(BYTE_IAC);
        send_byte(BYTE_SE);
    endtask

    initial begin
        int r;
        int i;
        logic [7:0] b;

        rx_predictor = new();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: editing and dropped bytes, escaped IAC, each option
        // command, a subnegotiation with an inner IAC, an unknown command,
        // erase on an empty line and an empty line.
        send_byte(8'h01);
        send_byte(8'hfe);
        send_byte(BYTE_BS);
        send_byte(8'h63);
        send_byte(BYTE_CR);
        send_byte(BYTE_NUL);
        send_byte(BYTE_LF);
        send_byte(BYTE_IAC);
        send_byte(BYTE_IAC);
        send_byte(BYTE_LF);
        send_option(BYTE_WILL, 8'h01);
        send_option(BYTE_DO, 8'hff);
        send_option(BYTE_WONT, 8'h03);
        send_option(BYTE_DONT, 8'h00);
        send_byte(BYTE_IAC);
        send_byte(BYTE_SB);
        send_byte(8'h18);
        send_byte(BYTE_IAC);
        send_byte(8'h01);
        send_byte(BYTE_IAC);
        send_byte(BYTE_SE);
        send_byte(BYTE_IAC);
        send_byte(8'hf1);
        send_byte(BYTE_DEL);
        send_byte(BYTE_LF);

        // A full line under a long receiver hold-off: erase at the limit,
        // refill, then read out the largest line the buffer can hold.
        hold_req = 1'b1;
        send_text(LINE_BYTES - 1, 1'b0);
        send_byte(BYTE_BS);
        send_byte(pick_text_byte());
        send_byte(BYTE_LF);

        // Overflowed line; erase after overflow must not revive it. Neither
        // side idles during this stretch.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        send_text(LINE_BYTES + 2, 1'b0);
        send_byte(BYTE_DEL);
        send_byte(BYTE_LF);
        idle_on  = 1'b1;
        stall_on = 1'b1;

        while (items_sent < 190) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                if ($urandom_range(0, 9) == 0)
                    send_text($urandom_range(LINE_BYTES - 6, LINE_BYTES + 6), 1'b1);
                else
                    send_text($urandom_range(0, 12), 1'b1);
                send_byte(BYTE_LF);
            end else if (r < 60) begin
                send_option(pick_option_cmd(), 8'($urandom_range(0, 255)));
            end else if (r < 70) begin
                send_subneg();
            end else if (r < 80) begin
                send_byte(BYTE_IAC);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == BYTE_IAC || b == BYTE_SB ||
                       (b >= BYTE_WILL && b <= BYTE_DONT));
                send_byte(b);
            end else begin
                // Noise can leave the parser in any mode.
                for (i = $urandom_range(1, 4); i > 0; i--)
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;
        stall_on = 1'b1;

        while (rx_predictor.due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (rx_predictor.errors == 0 && rx_predictor.due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
